[sv/isu_pkg.sv]
package isu_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

[sv/isu_cell.sv]
module isu_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  isu_pkg::cell_ctl_t ctl,
  input  isu_pkg::data_t    ins_value,
  input  isu_pkg::data_t    prev_value,
  input  logic              prev_valid,
  input  logic              prev_lt,
  input  isu_pkg::data_t    next_value,
  input  logic              next_valid,
  output isu_pkg::data_t    value,
  output logic              valid,
  output logic              lt
);
  import isu_pkg::*;

  data_t value_r, value_nxt;
  logic  valid_r, valid_nxt;

  // held entry lies below the new word, invalid counts as infinity
  assign lt = valid_r && (value_r < ins_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctl.insert) begin
      if (lt) begin
        value_nxt = value_r;
      end else if (prev_lt) begin
        value_nxt = ins_value;
      end else begin
        value_nxt = prev_value;
      end
      valid_nxt = valid_r | prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

[sv/insertion_sorter_unit.sv]
// insertion sorter: collects a set of signed 32-bit words and returns them in
// ascending order once the word flagged in_last_item has arrived.
// input channel: in_valid / in_ready with in_value and in_last_item. while a set
// is loading one word is taken every cycle; each word is broadcast to a row of
// MAX_ITEMS compare-and-shift cells, which insert it in place in ascending order.
// words arriving while all cells are full are dropped and the set is flagged.
// output channel: out_valid / out_ready with out_sorted_value, out_last_result
// (final word of the set) and out_overflowed (words of this set were dropped).
// after the last word is taken the state moves to DRAIN and the row drains
// towards cell 0, one word per cycle while the receiver does not stall; each
// word popped from cell 0 is registered in the output register.
// in_ready is low while the row drains; a stall on out_ready holds the output
// register and the row, and loading of the next set resumes as the final word
// moves into the output register.
// reset (rst_n low, synchronous) empties all cells and the output register.
module insertion_sorter_unit #(
  parameter int MAX_ITEMS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  isu_pkg::data_t in_value,
  input  logic           in_last_item,
  output logic           out_valid,
  input  logic           out_ready,
  output isu_pkg::data_t out_sorted_value,
  output logic           out_last_result,
  output logic           out_overflowed
);
  import isu_pkg::*;

  typedef enum logic {LOAD, DRAIN} state_t;

  state_t    state_r, state_nxt;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r;
  data_t     out_value_r;
  logic      out_last_r;
  logic      out_ovf_r;

  cell_ctl_t ctl;
  data_t     cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_vld;
  logic [MAX_ITEMS-1:0] cell_lt;

  logic accept_in, full, pop, pop_last;

  assign in_ready  = (state_r == LOAD);
  assign accept_in = in_valid && in_ready;
  assign full      = cell_vld[MAX_ITEMS-1];
  assign pop       = (state_r == DRAIN) && (!out_valid_r || out_ready);
  assign pop_last  = pop && !cell_vld[1];

  assign ctl.insert = accept_in && !full;
  assign ctl.shift  = pop;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    data_t pv, nv;
    logic  pvld, plt, nvld;
    if (i == 0) begin : g_head
      assign pv   = '0;
      assign pvld = 1'b1;
      assign plt  = 1'b1;
    end else begin : g_body
      assign pv   = cell_val[i-1];
      assign pvld = cell_vld[i-1];
      assign plt  = cell_lt[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_mid
      assign nv   = cell_val[i+1];
      assign nvld = cell_vld[i+1];
    end
    isu_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_value  (in_value),
      .prev_value (pv),
      .prev_valid (pvld),
      .prev_lt    (plt),
      .next_value (nv),
      .next_valid (nvld),
      .value      (cell_val[i]),
      .valid      (cell_vld[i]),
      .lt         (cell_lt[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      LOAD: begin
        if (accept_in && full) begin
          ovf_nxt = 1'b1;
        end
        if (accept_in && in_last_item) begin
          state_nxt = DRAIN;
        end
      end
      DRAIN: begin
        if (pop_last) begin
          state_nxt = LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_value_r <= cell_val[0];
      out_last_r  <= !cell_vld[1];
      out_ovf_r   <= ovf_r;
    end
    if (!rst_n) begin
      state_r     <= LOAD;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_result  = out_last_r;
  assign out_overflowed   = out_ovf_r;

`ifndef SYNTHESIS
  logic [MAX_ITEMS:0] vld_inc;
  assign vld_inc = {1'b0, cell_vld} + {{MAX_ITEMS{1'b0}}, 1'b1};

  // occupied cells always form a prefix of the row
  a_vld_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(vld_inc))
    else $error("cell valid bits not contiguous");

  // a set being drained is never empty
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DRAIN) |-> cell_vld[0])
    else $error("drain with empty row");

  // the final word leaves an empty row and a clear overflow flag
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    pop_last |=> (state_r == LOAD) && (cell_vld == '0) && !ovf_r)
    else $error("row not empty after final word");

  // the final word carries the last flag
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && (out_last_r == (state_r == LOAD)))
    else $error("last flag out of step with drain");
`endif

endmodule
